// File: hw/rtl/vgm_command_parser_macros.svh
// ----------------------------------------------------------------------------
// VGM command parser assertion macros
// Shared concurrent assertion forms, clocked on clk and gated by reset.
// ----------------------------------------------------------------------------
`ifndef VGM_COMMAND_PARSER_MACROS_SVH
`define VGM_COMMAND_PARSER_MACROS_SVH

// Same-cycle implication.
`define VGMCP_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("vgm_command_parser assertion failed");

// Next-cycle implication.
`define VGMCP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("vgm_command_parser assertion failed");

`endif

// File: hw/rtl/vgmcp_pkg.sv
// ----------------------------------------------------------------------------
// VGM command parser package
// Command codes, parse phases, event kinds and the structs shared by modules.
// ----------------------------------------------------------------------------
package vgmcp_pkg;

	localparam logic [7:0] CMD_WRITE_P0 = 8'h52;
	localparam logic [7:0] CMD_WRITE_P1 = 8'h53;
	localparam logic [7:0] CMD_SKIP_ONE = 8'h50;
	localparam logic [7:0] CMD_WAIT_N   = 8'h61;
	localparam logic [7:0] CMD_WAIT_LO  = 8'h70;
	localparam logic [7:0] CMD_WAIT_HI  = 8'h7f;
	localparam logic [7:0] CMD_END      = 8'h66;
	localparam logic [7:0] NIBBLE_MASK  = 8'h0f;

	localparam int unsigned TDATA_W = 64;
	localparam int unsigned TUSER_W = 3;

	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_ADDR    = 3'd1,
		PH_DATA    = 3'd2,
		PH_SKIP    = 3'd3,
		PH_WAIT_LO = 3'd4,
		PH_WAIT_HI = 3'd5,
		PH_DONE    = 3'd6
	} phase_t;

	typedef enum logic [2:0] {
		EV_WRITE0  = 3'd0,
		EV_WRITE1  = 3'd1,
		EV_WAIT    = 3'd2,
		EV_END     = 3'd3,
		EV_UNKNOWN = 3'd4
	} event_kind_t;

	typedef struct packed {
		phase_t      phase;
		logic        pending_port;
		logic [7:0]  held_byte;
		logic [31:0] sample_sum;
	} parse_state_t;

	typedef struct packed {
		logic        valid;
		event_kind_t kind;
		logic [7:0]  register_address;
		logic [7:0]  register_value;
		logic [15:0] wait_count;
		logic [31:0] samples_total;
	} parse_event_t;

endpackage

// File: hw/rtl/vgm_command_parser.sv
// ----------------------------------------------------------------------------
// VGM command parser
// Turns a headerless sound-log command byte stream into register-write,
// wait, end and unknown-command events with a running sample total.
// ----------------------------------------------------------------------------
// The parser takes one stream byte per clock cycle and puts each event out
// in the cycle after the byte that completes it; the throughput is set by the
// single output register, which refills in the same cycle that its beat is
// taken, so a stalled output holds up the input only while that register is
// full and not being read. Operand bytes produce no beat. After the end
// command, bytes are still accepted but give no event until reset.
module vgm_command_parser (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [7:0]                          s_tdata,  // [7:0] stream_byte
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [7:0] register_address, [15:8] register_value, [31:16] wait_count,
	// [63:32] samples_total
	output logic [vgmcp_pkg::TDATA_W-1:0]      m_tdata,
	output logic [vgmcp_pkg::TUSER_W-1:0]      m_tuser   // [2:0] event_kind
);

	vgmcp_pkg::parse_state_t state_q;
	vgmcp_pkg::parse_state_t state_nxt;
	vgmcp_pkg::parse_event_t evt;
	vgmcp_pkg::parse_event_t out_q;
	logic                    out_valid_q;
	logic                    in_beat;

	assign s_tready = !out_valid_q || m_tready;
	assign in_beat  = s_tvalid && s_tready;

	vgmcp_step u_step (
		.cur         (state_q),
		.stream_byte (s_tdata),
		.nxt         (state_nxt),
		.evt         (evt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase        <= vgmcp_pkg::PH_IDLE;
			state_q.pending_port <= 1'b0;
			state_q.held_byte    <= 8'd0;
			state_q.sample_sum   <= 32'd0;
			out_valid_q          <= 1'b0;
		end else begin
			if (in_beat) begin
				state_q     <= state_nxt;
				out_valid_q <= evt.valid;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat && evt.valid) begin
			out_q <= evt;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.kind;
	assign m_tdata  = {out_q.samples_total, out_q.wait_count,
	                   out_q.register_value, out_q.register_address};

endmodule

// File: hw/rtl/vgmcp_step.sv
// ----------------------------------------------------------------------------
// VGM command parser step
// Decodes one stream byte against the current parse state and yields the
// next state and at most one event.
// ----------------------------------------------------------------------------
module vgmcp_step (
	input  vgmcp_pkg::parse_state_t cur,
	input  logic [7:0]              stream_byte,
	output vgmcp_pkg::parse_state_t nxt,
	output vgmcp_pkg::parse_event_t evt
);

	logic [15:0] short_wait;
	logic [15:0] long_wait;

	assign short_wait = {8'd0, stream_byte & vgmcp_pkg::NIBBLE_MASK} + 16'd1;
	assign long_wait  = {stream_byte, cur.held_byte};

	always_comb begin
		nxt                  = cur;
		evt.valid            = 1'b0;
		evt.kind             = vgmcp_pkg::EV_UNKNOWN;
		evt.register_address = 8'd0;
		evt.register_value   = 8'd0;
		evt.wait_count       = 16'd0;
		evt.samples_total    = cur.sample_sum;

		case (cur.phase)
			vgmcp_pkg::PH_ADDR: begin
				nxt.held_byte = stream_byte;
				nxt.phase     = vgmcp_pkg::PH_DATA;
			end
			vgmcp_pkg::PH_DATA: begin
				nxt.phase            = vgmcp_pkg::PH_IDLE;
				evt.valid            = 1'b1;
				evt.kind             = cur.pending_port ? vgmcp_pkg::EV_WRITE1
				                                        : vgmcp_pkg::EV_WRITE0;
				evt.register_address = cur.held_byte;
				evt.register_value   = stream_byte;
			end
			vgmcp_pkg::PH_SKIP: begin
				nxt.phase = vgmcp_pkg::PH_IDLE;
			end
			vgmcp_pkg::PH_WAIT_LO: begin
				nxt.held_byte = stream_byte;
				nxt.phase     = vgmcp_pkg::PH_WAIT_HI;
			end
			vgmcp_pkg::PH_WAIT_HI: begin
				nxt.phase         = vgmcp_pkg::PH_IDLE;
				nxt.sample_sum    = cur.sample_sum + {16'd0, long_wait};
				evt.valid         = 1'b1;
				evt.kind          = vgmcp_pkg::EV_WAIT;
				evt.wait_count    = long_wait;
				evt.samples_total = nxt.sample_sum;
			end
			vgmcp_pkg::PH_IDLE: begin
				if (stream_byte == vgmcp_pkg::CMD_WRITE_P0 ||
				    stream_byte == vgmcp_pkg::CMD_WRITE_P1) begin
					nxt.pending_port = (stream_byte == vgmcp_pkg::CMD_WRITE_P1);
					nxt.phase        = vgmcp_pkg::PH_ADDR;
				end else if (stream_byte == vgmcp_pkg::CMD_SKIP_ONE) begin
					nxt.phase = vgmcp_pkg::PH_SKIP;
				end else if (stream_byte == vgmcp_pkg::CMD_WAIT_N) begin
					nxt.phase = vgmcp_pkg::PH_WAIT_LO;
				end else if (stream_byte >= vgmcp_pkg::CMD_WAIT_LO &&
				             stream_byte <= vgmcp_pkg::CMD_WAIT_HI) begin
					nxt.sample_sum    = cur.sample_sum + {16'd0, short_wait};
					evt.valid         = 1'b1;
					evt.kind          = vgmcp_pkg::EV_WAIT;
					evt.wait_count    = short_wait;
					evt.samples_total = nxt.sample_sum;
				end else if (stream_byte == vgmcp_pkg::CMD_END) begin
					nxt.phase = vgmcp_pkg::PH_DONE;
					evt.valid = 1'b1;
					evt.kind  = vgmcp_pkg::EV_END;
				end else begin
					evt.valid          = 1'b1;
					evt.kind           = vgmcp_pkg::EV_UNKNOWN;
					evt.register_value = stream_byte;
				end
			end
			default: begin
				// After the end command every byte is swallowed until reset.
				nxt.phase = vgmcp_pkg::PH_DONE;
			end
		endcase
	end

endmodule

// File: hw/rtl/vgmcp_checker.sv
// ----------------------------------------------------------------------------
// VGM command parser checker
// Port-level checks on the event stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "vgm_command_parser_macros.svh"

module vgmcp_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic [7:0]                     s_tdata,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [vgmcp_pkg::TDATA_W-1:0]  m_tdata,
	input logic [vgmcp_pkg::TUSER_W-1:0]  m_tuser
);

	// A held beat keeps its contents.
	`VGMCP_ASSERT_NEXT(a_hold_beat, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata) && $stable(m_tuser))

	// With the output register empty the input side must be open.
	`VGMCP_ASSERT_NOW(a_ready_when_empty, !m_tvalid, s_tready)

	// Only wait beats carry a sample count.
	`VGMCP_ASSERT_NOW(a_wait_only_on_wait,
		m_tvalid && m_tuser != vgmcp_pkg::EV_WAIT, m_tdata[31:16] == 16'd0)

	// Only writes carry a register address.
	`VGMCP_ASSERT_NOW(a_addr_only_on_write,
		m_tvalid && m_tuser != vgmcp_pkg::EV_WRITE0 && m_tuser != vgmcp_pkg::EV_WRITE1,
		m_tdata[7:0] == 8'd0)

	// Event kinds stay within the defined set.
	`VGMCP_ASSERT_NOW(a_kind_range, m_tvalid,
		m_tuser == vgmcp_pkg::EV_WRITE0 || m_tuser == vgmcp_pkg::EV_WRITE1 ||
		m_tuser == vgmcp_pkg::EV_WAIT || m_tuser == vgmcp_pkg::EV_END ||
		m_tuser == vgmcp_pkg::EV_UNKNOWN)

endmodule

bind vgm_command_parser vgmcp_checker u_vgmcp_checker (.*);

// File: tb/sv/vgm_event_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// VGM command parser event checker
// Follows every byte that the parser accepts, predicts the events that the
// byte stream must produce and compares each output beat with the oldest one.
// ----------------------------------------------------------------------------
module vgm_event_checker
	import vgmcp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [7:0]           s_tdata,
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [TDATA_W-1:0]   m_tdata,
	input  logic [TUSER_W-1:0]   m_tuser,
	output int unsigned          mismatches,
	output int unsigned          awaited,
	output int unsigned          events_checked,
	output logic                 total_wrapped
);

	typedef struct packed {
		event_kind_t kind;
		logic [7:0]  reg_addr;
		logic [7:0]  reg_value;
		logic [15:0] samples;
		logic [31:0] total;
	} parser_event_t;

	// Shadow copy of the parser state.
	phase_t      phase;
	logic        write_port;
	logic [7:0]  held;
	logic [31:0] sample_acc;

	parser_event_t expected_events[$];
	int unsigned   err_total;
	int unsigned   seen_total;
	logic          wrapped;

	function automatic parser_event_t make_event(event_kind_t kind, logic [7:0] reg_addr,
			logic [7:0] reg_value, logic [15:0] samples);
		parser_event_t ev;
		ev.kind      = kind;
		ev.reg_addr  = reg_addr;
		ev.reg_value = reg_value;
		ev.samples   = samples;
		ev.total     = sample_acc;
		return ev;
	endfunction

	task automatic add_samples(input logic [15:0] samples);
		logic [31:0] next_acc;
		next_acc = sample_acc + {16'd0, samples};
		if (next_acc < sample_acc) begin
			wrapped = 1'b1;
		end
		sample_acc = next_acc;
	endtask

	task automatic follow_byte(input logic [7:0] b);
		logic [15:0] samples;
		case (phase)
			PH_ADDR: begin
				held  = b;
				phase = PH_DATA;
			end
			PH_DATA: begin
				phase = PH_IDLE;
				expected_events.push_back(make_event(write_port ? EV_WRITE1 : EV_WRITE0,
					held, b, 16'd0));
			end
			PH_SKIP: begin
				phase = PH_IDLE;
			end
			PH_WAIT_LO: begin
				held  = b;
				phase = PH_WAIT_HI;
			end
			PH_WAIT_HI: begin
				samples = {b, held};
				add_samples(samples);
				phase = PH_IDLE;
				expected_events.push_back(make_event(EV_WAIT, 8'd0, 8'd0, samples));
			end
			PH_IDLE: begin
				if (b == CMD_WRITE_P0 || b == CMD_WRITE_P1) begin
					write_port = (b == CMD_WRITE_P1);
					phase      = PH_ADDR;
				end else if (b == CMD_SKIP_ONE) begin
					phase = PH_SKIP;
				end else if (b == CMD_WAIT_N) begin
					phase = PH_WAIT_LO;
				end else if (b >= CMD_WAIT_LO && b <= CMD_WAIT_HI) begin
					// Short waits carry the sample count minus one in the low nibble.
					samples = 16'(b & NIBBLE_MASK) + 16'd1;
					add_samples(samples);
					expected_events.push_back(make_event(EV_WAIT, 8'd0, 8'd0, samples));
				end else if (b == CMD_END) begin
					phase = PH_DONE;
					expected_events.push_back(make_event(EV_END, 8'd0, 8'd0, 16'd0));
				end else begin
					expected_events.push_back(make_event(EV_UNKNOWN, 8'd0, b, 16'd0));
				end
			end
			default: begin
				phase = PH_DONE;
			end
		endcase
	endtask

	function automatic void report_field(string field, longint unsigned want_v,
			longint unsigned got_v);
		err_total++;
		$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want_v, got_v);
	endfunction

	task automatic check_beat();
		parser_event_t got;
		parser_event_t want;
		got.kind      = event_kind_t'(m_tuser);
		got.reg_addr  = m_tdata[7:0];
		got.reg_value = m_tdata[15:8];
		got.samples   = m_tdata[31:16];
		got.total     = m_tdata[63:32];
		if (expected_events.size() == 0) begin
			err_total++;
			$display("%0t: event beat with nothing expected, expected none, %s %0d data 0x%h",
				$time, "actual kind", m_tuser, m_tdata);
		end else begin
			want = expected_events.pop_front();
			seen_total++;
			if (got.kind !== want.kind)
				report_field("event_kind", want.kind, m_tuser);
			if (got.reg_addr !== want.reg_addr)
				report_field("register_address", want.reg_addr, got.reg_addr);
			if (got.reg_value !== want.reg_value)
				report_field("register_value", want.reg_value, got.reg_value);
			if (got.samples !== want.samples)
				report_field("wait_count", want.samples, got.samples);
			if (got.total !== want.total)
				report_field("samples_total", want.total, got.total);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase      = PH_IDLE;
			write_port = 1'b0;
			held       = 8'd0;
			sample_acc = 32'd0;
			wrapped    = 1'b0;
			err_total  = 0;
			seen_total = 0;
			expected_events.delete();
		end else begin
			// Predicted events wait in the queue until their beats leave.
			if (s_tvalid && s_tready)
				follow_byte(s_tdata);
			if (m_tvalid && m_tready)
				check_beat();
		end
		mismatches     <= err_total;
		awaited        <= expected_events.size();
		events_checked <= seen_total;
		total_wrapped  <= wrapped;
	end

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// VGM command parser testbench
// Drives directed and random command byte streams into the parser and ends
// the stream; a checker module predicts and compares every event beat.
// ----------------------------------------------------------------------------
module tb;
	import vgmcp_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 50_000;
	localparam int unsigned RANDOM_BYTES = 1925;
	localparam int unsigned IDLE_PCT     = 23;

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [7:0]           s_tdata  = 8'd0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [TDATA_W-1:0]   m_tdata;
	logic [TUSER_W-1:0]   m_tuser;

	int unsigned mismatches;
	int unsigned awaited;
	int unsigned events_checked;
	logic        total_wrapped;

	int unsigned cycle_count   = 0;
	int unsigned bytes_sent    = 0;
	int unsigned operands_left = 0;
	logic        calm          = 1'b0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	vgm_command_parser u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	vgm_event_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tuser        (m_tuser),
		.mismatches     (mismatches),
		.awaited        (awaited),
		.events_checked (events_checked),
		.total_wrapped  (total_wrapped)
	);

	always @(posedge clk) begin
		m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Run stopped after %0d cycles with %0d events still awaited",
				cycle_count, awaited);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Tracks only where command bytes fall, so that the end command is never sent
	// by accident before the final part of the run.
	task automatic send_stream_byte(input logic [7:0] b, input logic end_ok);
		logic [7:0] beat;
		beat = b;
		if (operands_left == 0) begin
			if (beat == CMD_END && !end_ok)
				beat = CMD_END + 8'd1;
			case (beat)
				CMD_WRITE_P0, CMD_WRITE_P1, CMD_WAIT_N: operands_left = 2;
				CMD_SKIP_ONE:                           operands_left = 1;
				default:                                operands_left = 0;
			endcase
		end else begin
			operands_left--;
		end
		if (!calm) begin
			while ($urandom_range(0, 99) < IDLE_PCT) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata  <= beat;
		do @(posedge clk); while (!s_tready);
		bytes_sent++;
	endtask

	task automatic send_command(input logic [7:0] op, input int unsigned n_operands,
			input logic [15:0] operands);
		send_stream_byte(op, 1'b0);
		if (n_operands > 0)
			send_stream_byte(operands[7:0], 1'b0);
		if (n_operands > 1)
			send_stream_byte(operands[15:8], 1'b0);
	endtask

	task automatic drain_events();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (awaited != 0)
			@(posedge clk);
	endtask

	task automatic send_random_command();
		int unsigned pick;
		logic [7:0]  b;
		logic [15:0] count;
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			send_command($urandom_range(0, 1) ? CMD_WRITE_P1 : CMD_WRITE_P0, 2,
				16'($urandom_range(0, 16'hffff)));
		end else if (pick < 55) begin
			send_command(CMD_WAIT_LO | 8'($urandom_range(0, 15)), 0, 16'd0);
		end else if (pick < 70) begin
			count = 16'($urandom_range(0, 16'hffff));
			if ($urandom_range(0, 9) == 0)
				count = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
			send_command(CMD_WAIT_N, 2, count);
		end else if (pick < 80) begin
			send_command(CMD_SKIP_ONE, 1, 16'($urandom_range(0, 255)));
		end else if (pick < 90) begin
			b = 8'($urandom_range(0, 255));
			while (b == CMD_WRITE_P0 || b == CMD_WRITE_P1 || b == CMD_SKIP_ONE ||
					b == CMD_WAIT_N || b == CMD_END || (b >= CMD_WAIT_LO && b <= CMD_WAIT_HI))
				b = 8'($urandom_range(0, 255));
			send_command(b, 0, 16'd0);
		end else begin
			// Noise: loose bytes that may cut a command short or start one.
			repeat ($urandom_range(1, 3))
				send_stream_byte(8'($urandom_range(0, 255)), 1'b0);
		end
	endtask

	initial begin
		int unsigned random_start;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: field extremes, every command but the end command, zero and full
		// waits, and command-looking bytes in operand positions.
		send_command(CMD_WRITE_P0, 2, 16'hff00);
		send_command(CMD_WRITE_P1, 2, 16'h00ff);
		send_command(CMD_SKIP_ONE, 1, 16'(CMD_END));
		send_command(CMD_WAIT_N, 2, 16'h0000);
		send_command(CMD_WAIT_N, 2, 16'hffff);
		send_command(CMD_WAIT_LO, 0, 16'd0);
		send_command(CMD_WAIT_HI, 0, 16'd0);
		send_command(8'h00, 0, 16'd0);
		send_command(8'hff, 0, 16'd0);
		send_command(8'h6f, 0, 16'd0);
		send_command(CMD_WRITE_P0, 2, {CMD_WAIT_N, CMD_END});
		send_command(CMD_WRITE_P1, 2, {CMD_WRITE_P1, CMD_SKIP_ONE});
		drain_events();

		random_start = bytes_sent;
		while (bytes_sent - random_start < RANDOM_BYTES) begin
			calm = (bytes_sent - random_start >= 300) && (bytes_sent - random_start < 700);
			send_random_command();
		end
		calm = 1'b0;
		while (operands_left != 0)
			send_stream_byte(8'($urandom_range(0, 255)), 1'b0);

		// End of stream, then bytes that must be swallowed without events.
		send_stream_byte(CMD_END, 1'b1);
		send_command(CMD_WRITE_P0, 2, 16'h1234);
		send_command(CMD_WAIT_LO, 0, 16'd0);
		send_command(CMD_WAIT_N, 2, 16'h0001);
		send_command(8'h00, 0, 16'd0);
		drain_events();
		repeat (20) @(posedge clk);

		$display("Sent %0d stream bytes and checked %0d events: writes on both ports, waits,",
			bytes_sent, events_checked);
		$display("unknown commands, noise, end of stream; sample total wrapped: %s",
			total_wrapped ? "yes" : "no");
		if (mismatches == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// File: vgm_command_parser.f
+incdir+hw/rtl
hw/rtl/vgmcp_pkg.sv
hw/rtl/vgmcp_step.sv
hw/rtl/vgm_command_parser.sv
hw/rtl/vgmcp_checker.sv
tb/sv/vgm_event_checker.sv
tb/sv/tb.sv
